FILE: src/indexed_list_shift_store_defines.svh
// Assertion macros for the indexed list shift store.
// Depends on nothing; included by the top level that asserts.
`ifndef INDEXED_LIST_SHIFT_STORE_DEFINES_SVH
`define INDEXED_LIST_SHIFT_STORE_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define ILSS_ASSERT_SAME(name, clk, rst_n, pre, post) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error("ilss check failed");

// Next-cycle implication, sampled on the rising clock, off during reset.
`define ILSS_ASSERT_NEXT(name, clk, rst_n, pre, post) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("ilss check failed");

`endif

FILE: src/ilss_pkg.sv
// Shared types and codes for the indexed list shift store.
// Used by the cell, the request decoder and the top level; depends on nothing.
`default_nettype none

package ilss_pkg;

	// Widths of the request and result fields.
	localparam int FUNC_W   = 3;
	localparam int INDEX_W  = 6;
	localparam int VALUE_W  = 32;
	localparam int DATA_W   = 32;
	localparam int COUNT_W  = 7;
	localparam int STATUS_W = 2;

	// Operation codes.
	localparam logic [FUNC_W-1:0] OP_APPEND = 3'd0;
	localparam logic [FUNC_W-1:0] OP_INSERT = 3'd1;
	localparam logic [FUNC_W-1:0] OP_REMOVE = 3'd2;
	localparam logic [FUNC_W-1:0] OP_READ   = 3'd3;
	localparam logic [FUNC_W-1:0] OP_WRITE  = 3'd4;
	localparam logic [FUNC_W-1:0] OP_COUNT  = 3'd5;

	// Status codes.
	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

	// Per-cycle command broadcast to every cell of the row.
	typedef struct packed {
		logic shift_up;   // open a slot at pos, later cells take their left neighbor
		logic shift_down; // close the slot at pos, cells from pos take their right neighbor
		logic load;       // cell at pos takes the new word
	} cell_ctl_t;

	// Outcome of one request as seen by the result register.
	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic                rd_en;  // the word at pos is returned
	} req_res_t;

endpackage

`default_nettype wire

FILE: src/indexed_list_shift_store.sv
// Indexed list shift store: an ordered list of up to CAPACITY words held in a
// row of cells. Every request (append, insert, remove, read, overwrite, count)
// is decoded on the edge where it transfers, all cells shift or load together
// on that same edge, and the result sits in an output register from the next
// cycle on. A new request transfers in every cycle in which the output
// register is empty or is being drained, so the block sustains one request
// per clock; the limit is the parallel shift of the cell row plus the AND-OR
// read-out across all cells. Stored words have no reset and need no clearing
// pass; only the count and the result valid flag are cleared by reset.
// Depends on ilss_pkg, ilss_ctrl, ilss_cell and the assertion macro header.
`default_nettype none
`include "indexed_list_shift_store_defines.svh"

module indexed_list_shift_store
	import ilss_pkg::*;
#(
	parameter int CAPACITY   = 64,
	parameter int ELEM_WIDTH = 32
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire logic [FUNC_W-1:0]   func,
	input  wire logic [INDEX_W-1:0]  index,
	input  wire logic [VALUE_W-1:0]  value,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output logic      [DATA_W-1:0]   data,
	output logic      [COUNT_W-1:0]  count,
	output logic      [STATUS_W-1:0] status
);

	localparam int CW    = $clog2(CAPACITY + 1);
	localparam int POS_W = (CW > INDEX_W) ? CW : INDEX_W;

	logic                  accept;
	logic [CW-1:0]         count_q;
	logic [CW-1:0]         count_next;
	cell_ctl_t             ctl;
	req_res_t              res;
	logic [POS_W-1:0]      pos;
	logic [ELEM_WIDTH-1:0] val;
	logic [ELEM_WIDTH-1:0] cell_q  [CAPACITY];
	logic [ELEM_WIDTH-1:0] cell_rd [CAPACITY];
	logic [ELEM_WIDTH-1:0] rd_word;
	logic                  out_valid_q;
	logic [DATA_W-1:0]     data_q;
	logic [COUNT_W-1:0]    count_out_q;
	logic [STATUS_W-1:0]   status_q;

	// Input transfer whenever the result register is free or draining.
	assign in_ready = !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;
	assign val      = ELEM_WIDTH'(value);

	// Request decode.
	ilss_ctrl #(
		.CAPACITY (CAPACITY),
		.CW       (CW),
		.POS_W    (POS_W)
	) u_ctrl (
		.accept     (accept),
		.func       (func),
		.index      (index),
		.count_cur  (count_q),
		.ctl        (ctl),
		.pos        (pos),
		.count_next (count_next),
		.res        (res)
	);

	// Row of cells; the ends see zero from their missing neighbor.
	for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
		logic [ELEM_WIDTH-1:0] nb_left;
		logic [ELEM_WIDTH-1:0] nb_right;

		if (gi == 0) begin : g_first
			assign nb_left = '0;
		end else begin : g_mid_l
			assign nb_left = cell_q[gi-1];
		end

		if (gi == CAPACITY - 1) begin : g_last
			assign nb_right = '0;
		end else begin : g_mid_r
			assign nb_right = cell_q[gi+1];
		end

		ilss_cell #(
			.POS        (gi),
			.ELEM_WIDTH (ELEM_WIDTH),
			.POS_W      (POS_W)
		) u_cell (
			.clk   (clk),
			.ctl   (ctl),
			.pos   (pos),
			.val   (val),
			.left  (nb_left),
			.right (nb_right),
			.q     (cell_q[gi]),
			.rd    (cell_rd[gi])
		);
	end

	// Read-out: only the addressed cell drives a nonzero word.
	always_comb begin
		rd_word = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			rd_word = rd_word | cell_rd[i];
		end
	end

	// Entry count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (accept) begin
			count_q <= count_next;
		end
	end

	// Result register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result register payload.
	always_ff @(posedge clk) begin
		if (accept) begin
			data_q      <= res.rd_en ? DATA_W'(rd_word) : '0;
			count_out_q <= COUNT_W'(count_next);
			status_q    <= res.status;
		end
	end

	assign out_valid = out_valid_q;
	assign data      = data_q;
	assign count     = count_out_q;
	assign status    = status_q;

	// Checks on the count and the result path.
	`ILSS_ASSERT_SAME(a_count_bound, clk, arst_n, 1'b1, count_q <= CW'(CAPACITY))
	`ILSS_ASSERT_NEXT(a_append_grows, clk, arst_n,
		accept && func == OP_APPEND && count_q != CW'(CAPACITY),
		count_q == $past(count_q) + CW'(1))
	`ILSS_ASSERT_SAME(a_full_status, clk, arst_n,
		out_valid_q && status_q == ST_FULL, count_q == CW'(CAPACITY))
	`ILSS_ASSERT_SAME(a_stall_blocks, clk, arst_n, out_valid_q && !out_ready, !accept)

endmodule

`default_nettype wire

FILE: src/ilss_cell.sv
// One storage cell of the list row: holds one word and moves it to a neighbor.
// Depends on ilss_pkg for the command struct.
`default_nettype none

module ilss_cell
	import ilss_pkg::*;
#(
	parameter int POS        = 0,
	parameter int ELEM_WIDTH = 32,
	parameter int POS_W      = 7
) (
	input  wire logic                  clk,
	input  wire cell_ctl_t             ctl,
	input  wire logic [POS_W-1:0]      pos,
	input  wire logic [ELEM_WIDTH-1:0] val,
	input  wire logic [ELEM_WIDTH-1:0] left,
	input  wire logic [ELEM_WIDTH-1:0] right,
	output logic      [ELEM_WIDTH-1:0] q,
	output logic      [ELEM_WIDTH-1:0] rd
);

	localparam logic [POS_W-1:0] MY_POS = POS_W'(POS);

	logic                  at_pos;
	logic                  past_pos;
	logic [ELEM_WIDTH-1:0] word_q;

	assign at_pos   = (pos == MY_POS);
	assign past_pos = (pos < MY_POS);

	// Word storage: shifts toward either neighbor or loads the new word.
	always_ff @(posedge clk) begin
		if (ctl.shift_up) begin
			if (past_pos) begin
				word_q <= left;
			end else if (at_pos) begin
				word_q <= val;
			end
		end else if (ctl.shift_down) begin
			if (at_pos || past_pos) begin
				word_q <= right;
			end
		end else if (ctl.load && at_pos) begin
			word_q <= val;
		end
	end

	// The selected cell drives its word onto the shared read-out.
	assign q  = word_q;
	assign rd = at_pos ? word_q : '0;

endmodule

`default_nettype wire

FILE: src/ilss_ctrl.sv
// Request decoder: range and full checks, cell commands and the next count.
// Depends on ilss_pkg for codes and structs.
`default_nettype none

module ilss_ctrl
	import ilss_pkg::*;
#(
	parameter int CAPACITY = 64,
	parameter int CW       = 7,
	parameter int POS_W    = 7
) (
	input  wire logic                accept,
	input  wire logic [FUNC_W-1:0]   func,
	input  wire logic [INDEX_W-1:0]  index,
	input  wire logic [CW-1:0]       count_cur,
	output cell_ctl_t                ctl,
	output logic      [POS_W-1:0]    pos,
	output logic      [CW-1:0]       count_next,
	output req_res_t                 res
);

	logic [POS_W-1:0] idx_w;
	logic [POS_W-1:0] cnt_w;
	logic             in_range;
	logic             full;

	assign idx_w    = POS_W'(index);
	assign cnt_w    = POS_W'(count_cur);
	assign in_range = (idx_w < cnt_w);
	assign full     = (count_cur == CW'(CAPACITY));

	// Decode the operation; flagged requests leave the list untouched.
	always_comb begin
		ctl        = '0;
		pos        = idx_w;
		count_next = count_cur;
		res.status = ST_OK;
		res.rd_en  = 1'b0;
		case (func)
			OP_APPEND: begin
				pos = cnt_w;
				if (full) begin
					res.status = ST_FULL;
				end else begin
					ctl.load   = accept;
					count_next = count_cur + CW'(1);
				end
			end
			OP_INSERT: begin
				if (!in_range) begin
					res.status = ST_RANGE;
				end else if (full) begin
					res.status = ST_FULL;
				end else begin
					ctl.shift_up = accept;
					count_next   = count_cur + CW'(1);
				end
			end
			OP_REMOVE: begin
				if (!in_range) begin
					res.status = ST_RANGE;
				end else begin
					ctl.shift_down = accept;
					res.rd_en      = 1'b1;
					count_next     = count_cur - CW'(1);
				end
			end
			OP_READ: begin
				if (!in_range) begin
					res.status = ST_RANGE;
				end else begin
					res.rd_en = 1'b1;
				end
			end
			OP_WRITE: begin
				if (!in_range) begin
					res.status = ST_RANGE;
				end else begin
					ctl.load = accept;
				end
			end
			OP_COUNT: begin
				res.status = ST_OK;
			end
			default: begin
				res.status = ST_OK;
			end
		endcase
	end

endmodule

`default_nettype wire
